// ----- rtl/lsr_pkg.sv -----
// shared types, constants and channel arithmetic for the laplacian sharpen block
// no dependencies; imported by lsr_queue, lsr_front, lsr_back and the top level

package lsr_pkg;

	// configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_ALPHA  = 2'd0;
	localparam cfg_idx_t REG_WIDTH  = 2'd1;
	localparam cfg_idx_t REG_HEIGHT = 2'd2;

	localparam int CFG_W = 16;

	// one-hot result kinds caused by one input pixel, issued in this order
	typedef logic [2:0] job_t;
	localparam job_t JOB_UP  = 3'b001;	// pixel of the row above
	localparam job_t JOB_ROW = 3'b010;	// last row, pixel left of the current one
	localparam job_t JOB_END = 3'b100;	// last row, last column

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPW = $clog2(QUEUE_DEPTH);
	localparam int QLW = $clog2(QUEUE_DEPTH + 1);
	localparam int QSW = QLW + 1;

	// edge and job classification of one request
	typedef struct packed {
		job_t jobs;
		logic col_ge1;
		logic col_ge2;
		logic right_ok;
		logic row_ge1;
		logic row_ge2;
	} flags_t;

	// neighbourhood gathered for one request
	typedef struct packed {
		logic [31:0] pix;	// current pixel
		logic [31:0] ul;	// row above, column left
		logic [31:0] uc;	// row above, same column
		logic [31:0] ur;	// row above, column right
		logic [31:0] uu;	// two rows above, same column
		logic [31:0] m1;	// current row, one column left
		logic [31:0] m2;	// current row, two columns left
	} nbr_t;

	// color channel 0 = R, 1 = G, 2 = B
	function automatic logic [7:0] chan(input logic [31:0] px, input int idx);
		return px[31 - 8 * idx -: 8];
	endfunction

	// 4c - l - r - u - d, always within 11-bit signed range
	function automatic logic signed [10:0] lsr_delta(input logic [7:0] c, input logic [7:0] l,
			input logic [7:0] r, input logic [7:0] u, input logic [7:0] d);
		return $signed({1'b0, c, 2'b00} - {3'b000, l} - {3'b000, r} - {3'b000, u}
			- {3'b000, d});
	endfunction

	// c*4096 + gain*delta, clamped to 0..255*4096, then shifted down by 12
	function automatic logic [7:0] lsr_clamp(input logic [7:0] c, input logic signed [26:0] prod);
		logic signed [27:0] s;
		s = $signed({8'd0, c, 12'd0}) + $signed({prod[26], prod});
		if (s[27]) begin
			return 8'd0;
		end else if (s[26:20] != 7'd0) begin
			return 8'hFF;
		end else begin
			return s[19:12];
		end
	endfunction

endpackage

// ----- rtl/lsr_queue.sv -----
// short fifo that decouples the front (pixel intake) from the back (arithmetic)
// depends on lsr_pkg for the depth constants

module lsr_queue #(
	parameter int WIDTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [WIDTH-1:0]      push_data,
	input  logic                  pop,
	output logic                  empty,
	output logic [lsr_pkg::QLW-1:0] level,
	output logic [WIDTH-1:0]      head
);
	import lsr_pkg::*;

	logic [WIDTH-1:0] store_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QLW-1:0] level_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			case ({push, pop})
				2'b10: level_q <= level_q + QLW'(1);
				2'b01: level_q <= level_q - QLW'(1);
				default: level_q <= level_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	assign head  = store_q[rd_ptr_q];
	assign empty = (level_q == '0);
	assign level = level_q;

endmodule

// ----- rtl/lsr_front.sv -----
// front end: pixel intake, raster counters, two line memories and request classification
// depends on lsr_pkg; feeds lsr_queue

module lsr_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int CW         = 11,
	parameter int RW         = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_restart,
	input  logic [CW-1:0]          wm1,
	input  logic [RW-1:0]          hm1,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [31:0]            in_pixel,
	input  logic [lsr_pkg::QLW-1:0] q_level,
	output logic                   push,
	output lsr_pkg::flags_t        push_flags,
	output lsr_pkg::nbr_t          push_nbr,
	output logic [RW-1:0]          push_row,
	output logic [CW-1:0]          push_col
);
	import lsr_pkg::*;

	logic [31:0] line_prev  [MAX_WIDTH];
	logic [31:0] line_prev2 [MAX_WIDTH];

	logic acc;
	logic last_col;
	logic last_row;
	logic [CW-1:0] addr_r;
	flags_t flags_now;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [31:0] m1_q;
	logic [31:0] m2_q;

	logic valid_s1;
	logic [31:0] pix_s1;
	logic [31:0] ul_s1;
	logic [31:0] uc_s1;
	logic [31:0] ur_s1;
	logic [31:0] uu_s1;
	logic [31:0] m1_s1;
	logic [31:0] m2_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] col_s1;
	flags_t flags_s1;
	logic fwd_s1;
	logic [31:0] fwd_data_s1;

	// hold off input when the queue cannot take one more request
	assign in_stall = (QSW'(q_level) + QSW'(valid_s1)) >= QSW'(QUEUE_DEPTH);
	assign acc = in_valid && !in_stall;

	// classify the pixel by its place in the frame
	assign last_col = (col_q == wm1);
	assign last_row = (row_q == hm1);
	assign addr_r   = last_col ? col_q : col_q + CW'(1);

	always_comb begin
		flags_now.jobs     = {last_row && last_col, last_row && (col_q != '0), row_q != '0};
		flags_now.col_ge1  = (col_q != '0);
		flags_now.col_ge2  = (col_q > CW'(1));
		flags_now.right_ok = !last_col;
		flags_now.row_ge1  = (row_q != '0);
		flags_now.row_ge2  = (row_q > RW'(1));
	end

	// raster counters, restarted by any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// line above: two reads and one write per pixel, old data on a same-address read
	always_ff @(posedge clk) begin
		if (acc) begin
			line_prev[col_q] <= in_pixel;
			uc_s1 <= line_prev[col_q];
			ur_s1 <= line_prev[addr_r];
			uu_s1 <= line_prev2[col_q];
		end
	end

	// line two above takes the displaced entry in the cycle after it is read
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_prev2[col_s1] <= uc_s1;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
		end
	end

	// stage 1 payload and current-row history
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1      <= in_pixel;
			ul_s1       <= uc_s1;
			m1_s1       <= m1_q;
			m2_s1       <= m2_q;
			row_s1      <= row_q;
			col_s1      <= col_q;
			flags_s1    <= flags_now;
			m1_q        <= in_pixel;
			m2_q        <= m1_q;
			// one-column frame: the pending write of line two above is the answer
			fwd_s1      <= valid_s1 && (col_s1 == col_q);
			fwd_data_s1 <= uc_s1;
		end
	end

	// request to the queue, only when it causes at least one result
	assign push       = valid_s1 && (flags_s1.jobs != '0);
	assign push_flags = flags_s1;
	assign push_row   = row_s1;
	assign push_col   = col_s1;

	always_comb begin
		push_nbr.pix = pix_s1;
		push_nbr.ul  = ul_s1;
		push_nbr.uc  = uc_s1;
		push_nbr.ur  = ur_s1;
		push_nbr.uu  = fwd_s1 ? fwd_data_s1 : uu_s1;
		push_nbr.m1  = m1_s1;
		push_nbr.m2  = m2_s1;
	end

endmodule

// ----- rtl/lsr_back.sv -----
// back end: one result per clock from the queue head while not stalled; sharpen arithmetic
// depends on lsr_pkg; reads lsr_queue

module lsr_back #(
	parameter int CW = 11,
	parameter int RW = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [15:0]  alpha,
	input  logic                q_empty,
	input  lsr_pkg::flags_t     head_flags,
	input  lsr_pkg::nbr_t       head_nbr,
	input  logic [RW-1:0]       head_row,
	input  logic [CW-1:0]       head_col,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         out_pixel,
	output logic [RW-1:0]       out_row,
	output logic [CW-1:0]       out_col,
	output logic                run_last,
	output logic                frame_done
);
	import lsr_pkg::*;

	logic advance;
	logic issue;
	logic last;
	job_t pend;
	job_t cur;
	job_t done_q;

	logic [31:0] sel_c;
	logic [31:0] sel_l;
	logic [31:0] sel_r;
	logic [31:0] sel_u;
	logic [31:0] sel_d;
	logic [RW-1:0] sel_row;
	logic [CW-1:0] sel_col;
	logic sel_done;

	logic v_b1;
	logic signed [10:0] delta_b1 [3];
	logic [23:0] cen_b1;
	logic [7:0] a_b1;
	logic [RW-1:0] row_b1;
	logic [CW-1:0] col_b1;
	logic last_b1;
	logic done_b1;

	logic v_b2;
	logic signed [26:0] prod_b2 [3];
	logic [23:0] cen_b2;
	logic [7:0] a_b2;
	logic [RW-1:0] row_b2;
	logic [CW-1:0] col_b2;
	logic last_b2;
	logic done_b2;

	logic out_valid_q;
	logic [31:0] out_pixel_q;
	logic [RW-1:0] out_row_q;
	logic [CW-1:0] out_col_q;
	logic run_last_q;
	logic frame_done_q;

	// whole pipeline moves unless the output register is held
	assign advance = !out_valid_q || !out_stall;
	assign issue   = advance && !q_empty;

	// pick the next outstanding result of the head request
	assign pend = head_flags.jobs & ~done_q;
	always_comb begin
		if (pend[0]) begin
			cur = JOB_UP;
		end else if (pend[1]) begin
			cur = JOB_ROW;
		end else begin
			cur = JOB_END;
		end
	end
	assign last = ((pend & ~cur) == '0);
	assign pop  = issue && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (issue) begin
			done_q <= last ? '0 : (done_q | cur);
		end
	end

	// neighbourhood for the chosen result, edges clamped
	always_comb begin
		case (cur)
			JOB_UP: begin
				sel_c    = head_nbr.uc;
				sel_l    = head_flags.col_ge1 ? head_nbr.ul : head_nbr.uc;
				sel_r    = head_flags.right_ok ? head_nbr.ur : head_nbr.uc;
				sel_u    = head_flags.row_ge2 ? head_nbr.uu : head_nbr.uc;
				sel_d    = head_nbr.pix;
				sel_row  = head_row - RW'(1);
				sel_col  = head_col;
				sel_done = 1'b0;
			end
			JOB_ROW: begin
				sel_c    = head_nbr.m1;
				sel_l    = head_flags.col_ge2 ? head_nbr.m2 : head_nbr.m1;
				sel_r    = head_nbr.pix;
				sel_u    = head_flags.row_ge1 ? head_nbr.ul : head_nbr.m1;
				sel_d    = head_nbr.m1;
				sel_row  = head_row;
				sel_col  = head_col - CW'(1);
				sel_done = 1'b0;
			end
			JOB_END: begin
				sel_c    = head_nbr.pix;
				sel_l    = head_flags.col_ge1 ? head_nbr.m1 : head_nbr.pix;
				sel_r    = head_nbr.pix;
				sel_u    = head_flags.row_ge1 ? head_nbr.uc : head_nbr.pix;
				sel_d    = head_nbr.pix;
				sel_row  = head_row;
				sel_col  = head_col;
				sel_done = 1'b1;
			end
			default: begin
				sel_c    = head_nbr.pix;
				sel_l    = head_nbr.pix;
				sel_r    = head_nbr.pix;
				sel_u    = head_nbr.pix;
				sel_d    = head_nbr.pix;
				sel_row  = head_row;
				sel_col  = head_col;
				sel_done = 1'b0;
			end
		endcase
	end

	// stage valids and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1        <= 1'b0;
			v_b2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_b1        <= issue;
			v_b2        <= v_b1;
			out_valid_q <= v_b2;
		end
	end

	// b1: laplacian difference per channel
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				delta_b1[i] <= lsr_delta(chan(sel_c, i), chan(sel_l, i), chan(sel_r, i),
					chan(sel_u, i), chan(sel_d, i));
			end
			cen_b1  <= sel_c[31:8];
			a_b1    <= sel_c[7:0];
			row_b1  <= sel_row;
			col_b1  <= sel_col;
			last_b1 <= last;
			done_b1 <= sel_done;
		end
	end

	// b2: gain times difference
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < 3; i++) begin
				prod_b2[i] <= alpha * delta_b1[i];
			end
			cen_b2  <= cen_b1;
			a_b2    <= a_b1;
			row_b2  <= row_b1;
			col_b2  <= col_b1;
			last_b2 <= last_b1;
			done_b2 <= done_b1;
		end
	end

	// output register: add center, clamp, truncate
	always_ff @(posedge clk) begin
		if (advance) begin
			out_pixel_q  <= {lsr_clamp(cen_b2[23:16], prod_b2[0]),
				lsr_clamp(cen_b2[15:8], prod_b2[1]),
				lsr_clamp(cen_b2[7:0], prod_b2[2]), a_b2};
			out_row_q    <= row_b2;
			out_col_q    <= col_b2;
			run_last_q   <= last_b2;
			frame_done_q <= done_b2;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_pixel  = out_pixel_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign run_last   = run_last_q;
	assign frame_done = frame_done_q;

endmodule

// ----- rtl/laplacian_sharpen_rgba.sv -----
// top level of the 4-neighbour laplacian sharpen block: config registers and wiring
// depends on lsr_pkg, lsr_front, lsr_queue and lsr_back

// Takes RGBA8888 pixels in raster order, one per clock while in_stall is low, and returns
// each pixel sharpened as c + gain*(4c - left - right - up - down) on R, G and B (gain =
// alpha_q/4096, edges clamped, alpha byte copied), tagged with its row and column. A pixel
// of row i >= 1 releases pixel (i-1, j); on the last row a pixel also releases its left
// neighbour, and the frame's final pixel releases itself, flagged with frame_done. Results
// leave one per clock while out_stall is low, so rows other than the last run at one pixel
// per clock; on the last row the output side sets the pace and in_stall is raised while the
// 4-entry request queue fills. Two MAX_WIDTH x 32 line memories hold the rows above; they
// need no clearing after reset. Writing any register restarts the frame at row 0, column 0;
// write only while idle.

module laplacian_sharpen_rgba #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096,
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  lsr_pkg::cfg_idx_t           cfg_idx,
	input  logic [lsr_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [31:0]                 in_pixel,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [31:0]                 out_pixel,
	output logic [RW-1:0]               out_row,
	output logic [CW-1:0]               out_col,
	output logic                        run_last,
	output logic                        frame_done
);
	import lsr_pkg::*;

	localparam int QW = $bits(flags_t) + $bits(nbr_t) + RW + CW;

	logic signed [15:0] alpha_q;
	logic [11:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic cfg_restart;
	logic [CW-1:0] wm1;
	logic [RW-1:0] hm1;

	logic push;
	flags_t push_flags;
	nbr_t push_nbr;
	logic [RW-1:0] push_row;
	logic [CW-1:0] push_col;
	logic pop;
	logic q_empty;
	logic [QLW-1:0] q_level;
	logic [QW-1:0] q_head;
	flags_t head_flags;
	nbr_t head_nbr;
	logic [RW-1:0] head_row;
	logic [CW-1:0] head_col;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q        <= '0;
			frame_width_q  <= 12'd1;
			frame_height_q <= 13'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ALPHA:  alpha_q        <= cfg_wdata;
				REG_WIDTH:  frame_width_q  <= cfg_wdata[11:0];
				REG_HEIGHT: frame_height_q <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	assign cfg_restart = cfg_we && (cfg_idx inside {REG_ALPHA, REG_WIDTH, REG_HEIGHT});

	// effective last column and last row, zero acting as one and oversize saturating
	always_comb begin
		if (frame_width_q == '0) begin
			wm1 = '0;
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			wm1 = CW'(MAX_WIDTH - 1);
		end else begin
			wm1 = CW'(frame_width_q - 12'd1);
		end
		if (frame_height_q == '0) begin
			hm1 = '0;
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			hm1 = RW'(MAX_HEIGHT - 1);
		end else begin
			hm1 = RW'(frame_height_q - 13'd1);
		end
	end

	lsr_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW),
		.RW        (RW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_restart(cfg_restart),
		.wm1        (wm1),
		.hm1        (hm1),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_pixel   (in_pixel),
		.q_level    (q_level),
		.push       (push),
		.push_flags (push_flags),
		.push_nbr   (push_nbr),
		.push_row   (push_row),
		.push_col   (push_col)
	);

	lsr_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_flags, push_nbr, push_row, push_col}),
		.pop      (pop),
		.empty    (q_empty),
		.level    (q_level),
		.head     (q_head)
	);

	assign {head_flags, head_nbr, head_row, head_col} = q_head;

	lsr_back #(
		.CW(CW),
		.RW(RW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.alpha     (alpha_q),
		.q_empty   (q_empty),
		.head_flags(head_flags),
		.head_nbr  (head_nbr),
		.head_row  (head_row),
		.head_col  (head_col),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_pixel (out_pixel),
		.out_row   (out_row),
		.out_col   (out_col),
		.run_last  (run_last),
		.frame_done(frame_done)
	);

endmodule

// ----- rtl/lsr_checker.sv -----
// port-level checker for laplacian_sharpen_rgba, attached by the bind at the end
// depends only on the top level's ports

module lsr_checker #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096,
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_stall,
	input logic [31:0]   out_pixel,
	input logic [RW-1:0] out_row,
	input logic [CW-1:0] out_col,
	input logic          run_last,
	input logic          frame_done
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_pixel) && $stable(out_row)
			&& $stable(out_col) && $stable(run_last) && $stable(frame_done))
		else $error("result changed while stalled");

	// the frame's final pixel is always the last result of its request
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> run_last)
		else $error("frame_done without run_last");

	// nothing comes out in the first cycle after reset
	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result right after reset");

endmodule

bind laplacian_sharpen_rgba lsr_checker #(
	.MAX_WIDTH (MAX_WIDTH),
	.MAX_HEIGHT(MAX_HEIGHT)
) u_lsr_checker (.*);
